### rtl/gfinv_pkg.sv
// shared types and constants for the gf(2^m) inverter
package gfinv_pkg;

   localparam int FIELD_BITS_DEF = 16;
   localparam int MODULUS_RESET  = 19;

   // operation broadcast to every cell of the row
   typedef enum logic [2:0] {
      OP_HOLD     = 3'd0,
      OP_LOAD     = 3'd1,
      OP_NORM_SET = 3'd2,
      OP_NORM     = 3'd3,
      OP_REDUCE   = 3'd4,
      OP_MUL_SET  = 3'd5,
      OP_MUL      = 3'd6,
      OP_SWAP     = 3'd7
   } cell_op_type;

   typedef struct packed {
      cell_op_type op;
      logic        sub;   // quotient bit of this reduce step
      logic        qbit;  // quotient bit used by this multiply step
   } cell_ctrl_type;

endpackage

### rtl/gfinv_cell.sv
// one bit slice of the euclid datapath
module gfinv_cell (
   input  logic                     clock,
   input  gfinv_pkg::cell_ctrl_type ctrl,
   input  logic                     load_a,
   input  logic                     load_b,
   input  logic                     load_vb,
   input  logic                     s_lo,
   input  logic                     s_hi,
   input  logic                     t_lo,
   input  logic                     q_lo,
   input  logic                     q_hi,
   output logic                     a_out,
   output logic                     b_out,
   output logic                     s_out,
   output logic                     va_out,
   output logic                     t_out,
   output logic                     q_out
);
   import gfinv_pkg::*;

   logic a_ff, a_in, b_ff, b_in, s_ff, s_in;
   logic va_ff, va_in, vb_ff, vb_in, t_ff, t_in, q_ff, q_in;

   always_comb begin
      a_in  = a_ff;
      b_in  = b_ff;
      s_in  = s_ff;
      va_in = va_ff;
      vb_in = vb_ff;
      t_in  = t_ff;
      q_in  = q_ff;
      case (ctrl.op)
         OP_LOAD: begin
            a_in  = load_a;
            b_in  = load_b;
            va_in = 1'b0;
            vb_in = load_vb;
         end
         OP_NORM_SET: begin
            s_in = b_ff;
            q_in = 1'b0;
         end
         OP_NORM: begin
            s_in = s_lo;
         end
         OP_REDUCE: begin
            a_in = a_ff ^ (ctrl.sub & s_ff);
            s_in = s_hi;
            q_in = q_lo;
         end
         OP_MUL_SET: begin
            t_in = vb_ff;
         end
         OP_MUL: begin
            va_in = va_ff ^ (ctrl.qbit & t_ff);
            t_in  = t_lo;
            q_in  = q_hi;
         end
         OP_SWAP: begin
            a_in  = b_ff;
            b_in  = a_ff;
            va_in = vb_ff;
            vb_in = va_ff;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      a_ff  <= a_in;
      b_ff  <= b_in;
      s_ff  <= s_in;
      va_ff <= va_in;
      vb_ff <= vb_in;
      t_ff  <= t_in;
      q_ff  <= q_in;
   end

   assign a_out  = a_ff;
   assign b_out  = b_ff;
   assign s_out  = s_ff;
   assign va_out = va_ff;
   assign t_out  = t_ff;
   assign q_out  = q_ff;

endmodule

### rtl/gf2m_inverse_ext_euclid_core.sv
// gf(2^m) inverter by extended euclid on a row of bit-slice cells
//
// usage
//   req channel: req_element (valid/ready); one request is worked at a time,
//   req_ready is high only while the core is idle
//   rsp channel: rsp_inverse, rsp_found (valid/ready) from an output register;
//   a new request is taken while a finished result still waits there
//   config: apb-style port, modulus_poly at byte address 0 (reset x^4+x+1);
//   write it only while the core is idle
// timing
//   latency is data dependent; each euclid round is set by the
//   one-bit-per-cycle shifts of the divisor and cofactor along the row,
//   and a run also loads the operands, detects the end and hands off the
//   result; a zero element goes from the check straight to the finish state
// reset
//   synchronous reset clears the fsm and rsp_valid and restores the modulus
// stall
//   while the output register still holds a result and rsp_ready is low, a
//   finished result holds in the fsm until the output register frees up
module gf2m_inverse_ext_euclid_core #(
   parameter int FIELD_BITS = gfinv_pkg::FIELD_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [FIELD_BITS-1:0] req_element,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [FIELD_BITS-1:0] rsp_inverse,
   output logic                  rsp_found,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [2:0]            paddr,
   input  logic [31:0]           pwdata,
   output logic [31:0]           prdata,
   output logic                  pready
);
   import gfinv_pkg::*;

   localparam int NB = FIELD_BITS + 1;      // cells in the row
   localparam int PW = $clog2(NB);

   typedef enum logic [7:0] {
      ST_IDLE   = 8'b00000001,
      ST_CHECK  = 8'b00000010,
      ST_NORM   = 8'b00000100,
      ST_REDUCE = 8'b00001000,
      ST_MULI   = 8'b00010000,
      ST_MUL    = 8'b00100000,
      ST_SWAP   = 8'b01000000,
      ST_FINISH = 8'b10000000
   } state_type;

   state_type       state_ff, state_in;
   logic [NB-1:0]   modulus_ff, modulus_in;
   logic [PW-1:0]   shift_ff, shift_in;    // divisor alignment shift
   logic [PW-1:0]   cnt_ff, cnt_in;        // steps left after this one in reduce / multiply
   logic [PW-1:0]   pos_ff, pos_in;        // bit of r0 under the divisor top
   logic            rsp_valid_ff, rsp_valid_in;
   logic [FIELD_BITS-1:0] rsp_inverse_ff, rsp_inverse_in;
   logic            rsp_found_ff, rsp_found_in;

   cell_ctrl_type   ctrl;
   logic [NB-1:0]   a_vec, b_vec, s_vec, va_vec, t_vec, q_vec;
   logic [NB-1:0]   elem_ext;
   logic            out_free, found_now;

   // ---------------- configuration port
   assign pready     = 1'b1;
   assign prdata     = 32'(modulus_ff);
   assign modulus_in = (psel && penable && pwrite && (paddr[2] == 1'b0))
                       ? pwdata[NB-1:0] : modulus_ff;

   // ---------------- row of cells
   assign elem_ext = NB'(req_element);

   for (genvar i = 0; i < NB; i++) begin : g_cell
      logic s_lo, s_hi, t_lo, q_lo, q_hi;
      if (i == 0) begin : g_lo_edge
         assign s_lo = 1'b0;
         assign t_lo = 1'b0;
         assign q_lo = ctrl.sub;     // new quotient bit enters at the bottom
      end else begin : g_lo_mid
         assign s_lo = s_vec[i-1];
         assign t_lo = t_vec[i-1];
         assign q_lo = q_vec[i-1];
      end
      if (i == NB-1) begin : g_hi_edge
         assign s_hi = 1'b0;
         assign q_hi = 1'b0;
      end else begin : g_hi_mid
         assign s_hi = s_vec[i+1];
         assign q_hi = q_vec[i+1];
      end
      gfinv_cell u_cell (
         .clock   (clock),
         .ctrl    (ctrl),
         .load_a  (modulus_ff[i]),
         .load_b  (elem_ext[i]),
         .load_vb ((i == 0) ? 1'b1 : 1'b0),
         .s_lo    (s_lo),
         .s_hi    (s_hi),
         .t_lo    (t_lo),
         .q_lo    (q_lo),
         .q_hi    (q_hi),
         .a_out   (a_vec[i]),
         .b_out   (b_vec[i]),
         .s_out   (s_vec[i]),
         .va_out  (va_vec[i]),
         .t_out   (t_vec[i]),
         .q_out   (q_vec[i])
      );
   end

   // ---------------- sequencer
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign found_now = (a_vec == NB'(1)) && (va_vec[FIELD_BITS-1:0] != '0);
   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in       = state_ff;
      shift_in       = shift_ff;
      cnt_in         = cnt_ff;
      pos_in         = pos_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_inverse_in = rsp_inverse_ff;
      rsp_found_in   = rsp_found_ff;
      ctrl.op        = OP_HOLD;
      ctrl.sub       = 1'b0;
      ctrl.qbit      = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               ctrl.op  = OP_LOAD;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            // zero divisor ends euclid
            if (b_vec == '0) begin
               state_in = ST_FINISH;
            end else begin
               ctrl.op  = OP_NORM_SET;
               shift_in = '0;
               state_in = ST_NORM;
            end
         end
         ST_NORM: begin
            // slide the divisor up until its top bit sits in the last cell
            if (s_vec[NB-1]) begin
               pos_in   = PW'(NB-1);
               cnt_in   = shift_ff;
               state_in = ST_REDUCE;
            end else begin
               ctrl.op  = OP_NORM;
               shift_in = shift_ff + 1'b1;
            end
         end
         ST_REDUCE: begin
            ctrl.op  = OP_REDUCE;
            ctrl.sub = a_vec[pos_ff];
            pos_in   = pos_ff - 1'b1;
            if (cnt_ff == '0) begin
               state_in = ST_MULI;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         ST_MULI: begin
            ctrl.op  = OP_MUL_SET;
            cnt_in   = shift_ff;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            // v0 ^= q * v1, one quotient bit per cycle
            ctrl.op   = OP_MUL;
            ctrl.qbit = q_vec[0];
            if (cnt_ff == '0) begin
               state_in = ST_SWAP;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         ST_SWAP: begin
            ctrl.op  = OP_SWAP;
            state_in = ST_CHECK;
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_found_in   = found_now;
               rsp_inverse_in = found_now ? va_vec[FIELD_BITS-1:0] : '0;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         modulus_ff   <= NB'(MODULUS_RESET);
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         modulus_ff   <= modulus_in;
      end
      shift_ff       <= shift_in;
      cnt_ff         <= cnt_in;
      pos_ff         <= pos_in;
      rsp_inverse_ff <= rsp_inverse_in;
      rsp_found_ff   <= rsp_found_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_inverse = rsp_inverse_ff;
   assign rsp_found   = rsp_found_ff;

   // ---------------- checks
   a_accept_load: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == ST_CHECK))
      else $error("accepted request did not start a run");

   a_found_nonzero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_found) |-> (rsp_inverse != '0))
      else $error("found result with zero inverse");

   a_notfound_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_found) |-> (rsp_inverse == '0))
      else $error("missing inverse not reported as zero");

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_REDUCE || state_ff == ST_MUL) |-> (cnt_ff <= shift_ff))
      else $error("step count exceeds alignment shift");

   a_hold_result: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH && rsp_valid && !rsp_ready) |=> (state_ff == ST_FINISH))
      else $error("result left the sequencer while output was stalled");

endmodule
